>>> rtl/core/adaptive_playout_delay_control_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the adaptive playout delay control block
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_PLAYOUT_DELAY_CONTROL_MACROS_SVH
`define ADAPTIVE_PLAYOUT_DELAY_CONTROL_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define APDC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define APDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define APDC_ASSERT_IMPLY(lbl, ante, cons, msg)
`define APDC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/core/apdc_pkg.sv
// ----------------------------------------------------------------------------
// apdc_pkg
// widths and constants shared by the playout delay control files
// ----------------------------------------------------------------------------
package apdc_pkg;

    localparam int TICK_W       = 64;
    localparam int CATCHUP_W    = 32;
    localparam int DELTA_W      = 15;
    localparam int DELTA_WINDOW = 16;

    localparam logic [DELTA_W-1:0] DELTA_MAX   = '1;
    localparam logic [TICK_W-1:0]  TICK_ALL1   = '1;

    // target delay carries one more bit than a ring entry
    localparam int TARGET_W = DELTA_W + 1;

endpackage

>>> rtl/core/apdc_stream_if.sv
// ----------------------------------------------------------------------------
// apdc_stream_if
// request channel carrying the buffered range of one snapshot stream
// ----------------------------------------------------------------------------
interface apdc_stream_if;

    logic                        valid;
    logic                        ready;
    logic [apdc_pkg::TICK_W-1:0] oldest_tick;
    logic [apdc_pkg::TICK_W-1:0] latest_tick;
    logic                        last_stream;

    modport source
    (
        output valid,
        output oldest_tick,
        output latest_tick,
        output last_stream,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  oldest_tick,
        input  latest_tick,
        input  last_stream,
        output ready
    );

endinterface

>>> rtl/core/apdc_result_if.sv
// ----------------------------------------------------------------------------
// apdc_result_if
// result channel carrying one playback result
// ----------------------------------------------------------------------------
interface apdc_result_if;

    logic                           valid;
    logic                           ready;
    logic [apdc_pkg::TICK_W-1:0]    playback_tick;
    logic                           played;
    logic                           bumped;
    logic [apdc_pkg::TICK_W-1:0]    delay_now;
    logic [apdc_pkg::CATCHUP_W-1:0] catchup_left;
    logic                           last_of_tick;

    modport source
    (
        output valid,
        output playback_tick,
        output played,
        output bumped,
        output delay_now,
        output catchup_left,
        output last_of_tick,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  playback_tick,
        input  played,
        input  bumped,
        input  delay_now,
        input  catchup_left,
        input  last_of_tick,
        output ready
    );

endinterface

>>> rtl/core/adaptive_playout_delay_control.sv
// ----------------------------------------------------------------------------
// adaptive_playout_delay_control
// jitter buffer playout position and adaptive delay with catch-up steps
// ----------------------------------------------------------------------------
// Stream requests that are not the last of a tick update the min/max
// accumulators. The last request of a tick runs a playback step: BUMP and
// PLAY bump and play, then EMIT loads the result register. When the step
// plays and the smallest latest tick has changed, it also writes the delta
// ring memory and walks it one entry a cycle to find the largest change,
// passing through SCAN, DRAIN and CALC before the result is loaded.
// With a catch-up pending a second step follows, which never writes the ring.
// EMIT waits while the result register is held on the downstream side. The
// ring needs no clearing pass: per-entry valid bits make unwritten entries
// read as zero.
// ----------------------------------------------------------------------------
module adaptive_playout_delay_control
#(
    parameter int DELTA_WINDOW = apdc_pkg::DELTA_WINDOW
)
(
    input  logic          clk,
    input  logic          rst_n,
    apdc_stream_if.sink   stream,
    apdc_result_if.source result
);

    `include "adaptive_playout_delay_control_macros.svh"

    localparam int TW = apdc_pkg::TICK_W;
    localparam int CW = apdc_pkg::CATCHUP_W;
    localparam int DW = apdc_pkg::DELTA_W;
    localparam int GW = apdc_pkg::TARGET_W;
    localparam int AW = (DELTA_WINDOW > 1) ? $clog2(DELTA_WINDOW) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DELTA_WINDOW - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BUMP  = 3'd1;
    localparam logic [2:0] S_PLAY  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_CALC  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    // control state
    logic [2:0]              state_reg,      state_next;
    logic [TW-1:0]           min_acc_reg,    min_acc_next;
    logic [TW-1:0]           max_acc_reg,    max_acc_next;
    logic [TW-1:0]           next_play_reg,  next_play_next;
    logic [TW-1:0]           prev_min_reg,   prev_min_next;
    logic [TW-1:0]           delay_reg,      delay_next;
    logic [AW-1:0]           ring_pos_reg,   ring_pos_next;
    logic [DELTA_WINDOW-1:0] ring_vld_reg,   ring_vld_next;
    logic [CW-1:0]           catchup_reg,    catchup_next;
    logic                    step2_reg,      step2_next;
    logic                    out_valid_reg,  out_valid_next;
    logic                    rd_vld_reg,     rd_vld_next;

    // working payload
    logic [TW-1:0]           lo_reg,         lo_next;
    logic [TW-1:0]           hi_reg,         hi_next;
    logic [TW-1:0]           res_tick_reg,   res_tick_next;
    logic                    res_played_reg, res_played_next;
    logic                    res_bumped_reg, res_bumped_next;
    logic [DW-1:0]           big_reg,        big_next;
    logic [AW-1:0]           scan_idx_reg,   scan_idx_next;
    logic                    rd_ent_vld_reg;
    logic [DW-1:0]           rd_data_reg;

    // result register
    logic [TW-1:0]           out_tick_reg;
    logic                    out_played_reg;
    logic                    out_bumped_reg;
    logic [TW-1:0]           out_delay_reg;
    logic [CW-1:0]           out_catchup_reg;
    logic                    out_last_reg;

    // delta ring memory
    logic [DW-1:0]           ring_mem [DELTA_WINDOW];
    logic                    mem_we;
    logic [DW-1:0]           mem_wdata;

    logic                    stream_fire;
    logic                    slot_free;
    logic                    out_load;
    logic [TW-1:0]           lo_in;
    logic [TW-1:0]           hi_in;
    logic                    play;
    logic [TW-1:0]           delta;
    logic [DW-1:0]           delta_sat;
    logic [DW-1:0]           rd_value;
    logic [GW-1:0]           target;
    logic [TW-1:0]           excess;

    assign stream.ready = (state_reg == S_IDLE);
    assign stream_fire  = stream.valid && stream.ready;
    assign slot_free    = !out_valid_reg || result.ready;
    assign out_load     = (state_reg == S_EMIT) && slot_free;

    assign lo_in = (stream.latest_tick < min_acc_reg) ? stream.latest_tick : min_acc_reg;
    assign hi_in = (stream.oldest_tick > max_acc_reg) ? stream.oldest_tick : max_acc_reg;

    assign play  = (lo_reg >= next_play_reg);
    assign delta = lo_reg - prev_min_reg;

    // negative change enters as zero, large change saturates
    assign delta_sat = delta[TW-1]            ? '0 :
                       (|delta[TW-2:DW])      ? apdc_pkg::DELTA_MAX :
                       delta[DW-1:0];
    assign mem_wdata = delta_sat;

    assign rd_value = rd_ent_vld_reg ? rd_data_reg : '0;
    assign target   = GW'(big_reg) + GW'(big_reg >> 6) + GW'(1);
    assign excess   = delay_reg - TW'(target);

    always_comb
    begin
        state_next      = state_reg;
        min_acc_next    = min_acc_reg;
        max_acc_next    = max_acc_reg;
        next_play_next  = next_play_reg;
        prev_min_next   = prev_min_reg;
        delay_next      = delay_reg;
        ring_pos_next   = ring_pos_reg;
        ring_vld_next   = ring_vld_reg;
        catchup_next    = catchup_reg;
        step2_next      = step2_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        res_tick_next   = res_tick_reg;
        res_played_next = res_played_reg;
        res_bumped_next = res_bumped_reg;
        scan_idx_next   = scan_idx_reg;
        mem_we          = 1'b0;
        rd_vld_next     = (state_reg == S_SCAN);
        out_valid_next  = (out_valid_reg && result.ready) ? 1'b0 : out_valid_reg;

        // running maximum over the ring read data
        big_next = big_reg;
        if (rd_vld_reg && (rd_value > big_reg))
        begin
            big_next = rd_value;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (stream_fire)
                begin
                    if (stream.last_stream)
                    begin
                        lo_next      = lo_in;
                        hi_next      = hi_in;
                        min_acc_next = apdc_pkg::TICK_ALL1;
                        max_acc_next = '0;
                        step2_next   = 1'b0;
                        state_next   = S_BUMP;
                    end
                    else
                    begin
                        min_acc_next = lo_in;
                        max_acc_next = hi_in;
                    end
                end
            end
            S_BUMP:
            begin
                res_bumped_next = (hi_reg > next_play_reg);
                if (hi_reg > next_play_reg)
                begin
                    next_play_next = hi_reg;
                end
                state_next = S_PLAY;
            end
            S_PLAY:
            begin
                res_tick_next   = next_play_reg;
                res_played_next = play;
                state_next      = S_EMIT;
                if (play)
                begin
                    delay_next     = lo_reg - next_play_reg;
                    next_play_next = next_play_reg + TW'(1);
                    if (lo_reg != prev_min_reg)
                    begin
                        prev_min_next               = lo_reg;
                        mem_we                      = 1'b1;
                        ring_vld_next[ring_pos_reg] = 1'b1;
                        ring_pos_next = (ring_pos_reg == LAST_IDX) ? '0
                                                                   : ring_pos_reg + AW'(1);
                        scan_idx_next = '0;
                        big_next      = '0;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (delay_reg > TW'(target))
                begin
                    catchup_next = (|excess[TW-1:CW]) ? '1 : excess[CW-1:0];
                end
                else
                begin
                    catchup_next = '0;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (!step2_reg && (catchup_reg != '0))
                    begin
                        catchup_next = catchup_reg - CW'(1);
                        step2_next   = 1'b1;
                        state_next   = S_BUMP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_acc_reg   <= apdc_pkg::TICK_ALL1;
            max_acc_reg   <= '0;
            next_play_reg <= '0;
            prev_min_reg  <= '0;
            delay_reg     <= '0;
            ring_pos_reg  <= '0;
            ring_vld_reg  <= '0;
            catchup_reg   <= '0;
            step2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            min_acc_reg   <= min_acc_next;
            max_acc_reg   <= max_acc_next;
            next_play_reg <= next_play_next;
            prev_min_reg  <= prev_min_next;
            delay_reg     <= delay_next;
            ring_pos_reg  <= ring_pos_next;
            ring_vld_reg  <= ring_vld_next;
            catchup_reg   <= catchup_next;
            step2_reg     <= step2_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg    <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        res_tick_reg   <= res_tick_next;
        res_played_reg <= res_played_next;
        res_bumped_reg <= res_bumped_next;
        big_reg        <= big_next;
        scan_idx_reg   <= scan_idx_next;
        rd_ent_vld_reg <= ring_vld_reg[scan_idx_reg];
        if (out_load)
        begin
            out_tick_reg    <= res_tick_reg;
            out_played_reg  <= res_played_reg;
            out_bumped_reg  <= res_bumped_reg;
            out_delay_reg   <= delay_reg;
            out_catchup_reg <= catchup_reg;
            out_last_reg    <= step2_reg || (catchup_reg == '0);
        end
    end

    // ring memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[ring_pos_reg] <= mem_wdata;
        end
        rd_data_reg <= ring_mem[scan_idx_reg];
    end

    assign result.valid         = out_valid_reg;
    assign result.playback_tick = out_tick_reg;
    assign result.played        = out_played_reg;
    assign result.bumped        = out_bumped_reg;
    assign result.delay_now     = out_delay_reg;
    assign result.catchup_left  = out_catchup_reg;
    assign result.last_of_tick  = out_last_reg;

    `APDC_ASSERT_NEXT(a_last_blocks_input, stream_fire && stream.last_stream, !stream.ready, "input taken while a tick is in playback")
    `APDC_ASSERT_NEXT(a_catchup_decrement, out_load && !step2_reg && (catchup_reg != '0), catchup_reg == $past(catchup_reg) - CW'(1), "catch-up count not decremented for second step")
    `APDC_ASSERT_NEXT(a_second_is_last, out_load && step2_reg, out_last_reg && out_valid_reg, "second result of a tick not marked last")
    `APDC_ASSERT_NEXT(a_play_advances, (state_reg == S_PLAY) && play, next_play_reg == $past(next_play_reg) + TW'(1), "playback position did not advance after a play")

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for adaptive_playout_delay_control: stream requests go
// in with random gaps, playback results come out under random backpressure,
// and a scoreboard predicts each result from its own copy of the playout state
// ----------------------------------------------------------------------------

typedef struct packed
{
    logic [apdc_pkg::TICK_W-1:0]    playback_tick;
    logic                           played;
    logic                           bumped;
    logic [apdc_pkg::TICK_W-1:0]    delay_now;
    logic [apdc_pkg::CATCHUP_W-1:0] catchup_left;
    logic                           last_of_tick;
} playback_t;

class playout_scoreboard;

    localparam int HIST_N = apdc_pkg::DELTA_WINDOW;

    logic [apdc_pkg::TICK_W-1:0]    min_latest;
    logic [apdc_pkg::TICK_W-1:0]    max_oldest;
    logic [apdc_pkg::TICK_W-1:0]    play_pos;
    logic [apdc_pkg::TICK_W-1:0]    last_min_latest;
    logic [apdc_pkg::TICK_W-1:0]    delay;
    logic [apdc_pkg::DELTA_W-1:0]   delta_hist [HIST_N];
    int unsigned                    hist_pos;
    logic [apdc_pkg::CATCHUP_W-1:0] catchup;

    playback_t   playback_queue[$];
    int unsigned mismatches;
    int unsigned ticks;
    int unsigned results;
    int unsigned double_ticks;
    int unsigned starved;
    int unsigned bumps;
    int unsigned wraps;

    function new();
        min_latest      = apdc_pkg::TICK_ALL1;
        max_oldest      = '0;
        play_pos        = '0;
        last_min_latest = '0;
        delay           = '0;
        foreach (delta_hist[i])
            delta_hist[i] = '0;
        hist_pos        = 0;
        catchup         = '0;
    endfunction

    task report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch: %s", what);
    endtask

    function int unsigned pending();
        return playback_queue.size();
    endfunction

    function playback_t play_step(input bit last_step);
        logic [apdc_pkg::TICK_W-1:0]  diff;
        logic [apdc_pkg::DELTA_W-1:0] clamped;
        logic [apdc_pkg::DELTA_W-1:0] biggest;
        logic [apdc_pkg::TICK_W-1:0]  target;
        logic [apdc_pkg::TICK_W-1:0]  excess;
        playback_t                    r;
        r = '0;
        if (max_oldest > play_pos)
        begin
            play_pos = max_oldest;
            r.bumped = 1'b1;
            bumps++;
        end
        r.playback_tick = play_pos;
        if (min_latest >= play_pos)
        begin
            delay = min_latest - play_pos;
            if (last_min_latest != min_latest)
            begin
                diff = min_latest - last_min_latest;
                // a backwards move counts as no change, big jumps clamp
                if (diff[apdc_pkg::TICK_W-1])
                    clamped = '0;
                else if (diff > apdc_pkg::TICK_W'(apdc_pkg::DELTA_MAX))
                    clamped = apdc_pkg::DELTA_MAX;
                else
                    clamped = diff[apdc_pkg::DELTA_W-1:0];
                last_min_latest = min_latest;
                delta_hist[hist_pos] = clamped;
                hist_pos = (hist_pos + 1) % HIST_N;
                biggest = '0;
                foreach (delta_hist[i])
                    if (delta_hist[i] > biggest)
                        biggest = delta_hist[i];
                target = apdc_pkg::TICK_W'(biggest) + apdc_pkg::TICK_W'(biggest / 64) + 1;
                if (target < delay)
                begin
                    excess  = delay - target;
                    catchup = (excess > 64'h0000_0000_FFFF_FFFF) ? '1 : excess[31:0];
                end
                else
                begin
                    catchup = '0;
                end
            end
            r.played = 1'b1;
            if (play_pos == apdc_pkg::TICK_ALL1)
                wraps++;
            play_pos = play_pos + 1;
        end
        else
        begin
            starved++;
        end
        r.delay_now    = delay;
        r.catchup_left = catchup;
        r.last_of_tick = last_step;
        return r;
    endfunction

    function void note_request(input logic [63:0] oldest, input logic [63:0] latest,
                               input bit last);
        playback_t first;
        if (latest < min_latest)
            min_latest = latest;
        if (oldest > max_oldest)
            max_oldest = oldest;
        if (!last)
            return;
        ticks++;
        first = play_step(1'b0);
        if (catchup != 0)
        begin
            catchup = catchup - 1;
            playback_queue.push_back(first);
            playback_queue.push_back(play_step(1'b1));
            double_ticks++;
        end
        else
        begin
            first.last_of_tick = 1'b1;
            playback_queue.push_back(first);
        end
        min_latest = apdc_pkg::TICK_ALL1;
        max_oldest = '0;
    endfunction

    task check_result(input playback_t got);
        playback_t want;
        if (playback_queue.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with none expected", results));
            return;
        end
        want = playback_queue.pop_front();
        if (got.playback_tick !== want.playback_tick)
            report_mismatch($sformatf("result %0d playback_tick %h, want %h",
                                      results, got.playback_tick, want.playback_tick));
        if (got.played !== want.played)
            report_mismatch($sformatf("result %0d played %b, want %b",
                                      results, got.played, want.played));
        if (got.bumped !== want.bumped)
            report_mismatch($sformatf("result %0d bumped %b, want %b",
                                      results, got.bumped, want.bumped));
        if (got.delay_now !== want.delay_now)
            report_mismatch($sformatf("result %0d delay_now %h, want %h",
                                      results, got.delay_now, want.delay_now));
        if (got.catchup_left !== want.catchup_left)
            report_mismatch($sformatf("result %0d catchup_left %h, want %h",
                                      results, got.catchup_left, want.catchup_left));
        if (got.last_of_tick !== want.last_of_tick)
            report_mismatch($sformatf("result %0d last_of_tick %b, want %b",
                                      results, got.last_of_tick, want.last_of_tick));
        results++;
    endtask

endclass

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    RANDOM_ITEMS = 2000;
    localparam int    DRAIN_CYCLES = 2 * apdc_pkg::DELTA_WINDOW + 20;
    localparam longint CYCLE_LIMIT = 400000;

    bit          clk;
    logic        rst_n;
    bit          steady;
    longint      cycles;
    int unsigned items_sent;

    playout_scoreboard sb;

    apdc_stream_if stream();
    apdc_result_if result();

    adaptive_playout_delay_control u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .result (result)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // downstream backpressure
    always @(negedge clk)
        result.ready <= steady || ($urandom_range(0, 99) >= 15);

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
            sb.check_result('{result.playback_tick, result.played, result.bumped,
                              result.delay_now, result.catchup_left, result.last_of_tick});
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_request(input logic [63:0] oldest, input logic [63:0] latest,
                                input bit last);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < 15)
            begin
                stream.valid <= 1'b0;
                @(negedge clk);
            end
        end
        stream.valid       <= 1'b1;
        stream.oldest_tick <= oldest;
        stream.latest_tick <= latest;
        stream.last_stream <= last;
        do
            @(posedge clk);
        while (!stream.ready);
        sb.note_request(oldest, latest, last);
        items_sent++;
        @(negedge clk);
    endtask

    // one tick of plausible stream ranges placed around the playout position
    task automatic send_tick();
        int unsigned       n_streams;
        int unsigned       mode;
        logic [63:0]       pos;
        logic [63:0]       lag;
        logic [63:0]       latest;
        logic [63:0]       oldest;
        n_streams = $urandom_range(1, 4);
        mode      = $urandom_range(0, 9);
        pos       = sb.play_pos;
        if (mode <= 5)
            lag = $urandom_range(0, 24);
        else if (mode <= 7)
            lag = $urandom_range(25, 300);
        else
            lag = $urandom_range(300, 70000);
        for (int s = 0; s < n_streams; s++)
        begin
            if (mode == 9 && $urandom_range(0, 1) == 0)
                latest = pos - $urandom_range(1, 5);
            else
                latest = pos + lag + $urandom_range(0, 8);
            oldest = latest - $urandom_range(0, 40);
            if ($urandom_range(0, 7) == 0)
                oldest = pos + $urandom_range(1, 3);
            send_request(oldest, latest, s == n_streams - 1);
        end
    endtask

    initial
    begin
        sb                 = new();
        rst_n              = 1'b0;
        steady             = 1'b0;
        cycles             = 0;
        items_sent         = 0;
        stream.valid       = 1'b0;
        stream.oldest_tick = '0;
        stream.latest_tick = '0;
        stream.last_stream = 1'b0;
        result.ready       = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: first tick at zero, multi-stream tick, clamped jump
        send_request(64'd0, 64'd0, 1'b1);
        send_request(64'd5, 64'd100, 1'b0);
        send_request(64'd3, 64'd90, 1'b1);
        send_request(64'd10, 64'd200000, 1'b1);
        // latest tick moves backwards, then a tick with no data to play
        send_request(64'd20, 64'd150, 1'b1);
        send_request(64'd30, 64'd25, 1'b1);
        send_request(64'd31, 64'd40, 1'b0);
        send_request(64'd29, 64'd36, 1'b1);
        // huge delay saturates the catch-up count
        send_request(64'd0, 64'h8000_0000_0000_1234, 1'b1);
        send_request(64'd0, 64'h8000_0000_0000_1240, 1'b1);
        // position at all ones wraps to zero
        send_request(apdc_pkg::TICK_ALL1, apdc_pkg::TICK_ALL1, 1'b1);
        send_request(64'd0, 64'd0, 1'b1);
        send_request(64'd0, 64'd3, 1'b1);
        send_request(apdc_pkg::TICK_ALL1, 64'd0, 1'b0);
        send_request(64'd0, apdc_pkg::TICK_ALL1, 1'b1);
        send_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        send_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1);

        while (items_sent < RANDOM_ITEMS)
        begin
            steady = (items_sent >= 900 && items_sent < 1200);
            if ($urandom_range(0, 99) < 85)
            begin
                send_tick();
            end
            else
            begin
                // noise: arbitrary ranges, often out of order
                send_request(rand64(), rand64(), $urandom_range(0, 1));
            end
        end
        steady = 1'b0;
        stream.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        while (sb.pending() != 0)
            sb.report_mismatch("expected result never arrived");
        $display("%0d requests, %0d ticks, %0d results checked in %0d cycles",
                 items_sent, sb.ticks, sb.results, cycles);
        $display("%0d double-step ticks, %0d starved steps, %0d bumps, %0d wraps",
                 sb.double_ticks, sb.starved, sb.bumps, sb.wraps);
        if (sb.mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/apdc_pkg.sv
rtl/core/apdc_stream_if.sv
rtl/core/apdc_result_if.sv
rtl/core/adaptive_playout_delay_control.sv
sim/tb.sv
